>>> design/esc_pkg.sv
package esc_pkg;

	// stream widths
	localparam int IN_W  = 32;
	localparam int OUT_W = 40;  // 38 field bits, zero-filled to whole bytes

	// field widths
	localparam int YEAR_W  = 12;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;
	localparam int FIELD_W = YEAR_W + MONTH_W + DAY_W + HOUR_W + MIN_W + SEC_W;

	// remainder and step-length widths (366 days of seconds fits in 25 bits)
	localparam int REM_W = 32;
	localparam int LEN_W = 25;

	localparam logic [YEAR_W-1:0]  BASE_YEAR  = YEAR_W'(1970);
	localparam logic [YEAR_W-1:0]  NOLEAP_CENTURY = YEAR_W'(2100);
	localparam logic [MONTH_W-1:0] MONTH_LAST = MONTH_W'(11);

	localparam logic [LEN_W-1:0] SECS_PER_MIN  = LEN_W'(60);
	localparam logic [LEN_W-1:0] SECS_PER_HOUR = LEN_W'(60 * 60);
	localparam logic [LEN_W-1:0] SECS_PER_DAY  = LEN_W'(24 * 60 * 60);
	localparam logic [LEN_W-1:0] SECS_YEAR     = LEN_W'(365 * 24 * 60 * 60);
	localparam logic [LEN_W-1:0] SECS_LEAP_YEAR = LEN_W'(366 * 24 * 60 * 60);

	// microcode
	localparam int UPC_W = 3;
	typedef logic [UPC_W-1:0] upc_t;

	typedef enum logic [1:0] {
		OP_WAIT,  // idle, take the next input word
		OP_LOOP,  // subtract length while it fits, else jump
		OP_EMIT   // hand result to output register, then jump
	} op_t;

	typedef enum logic [2:0] {
		SEL_YEAR,
		SEL_MONTH,
		SEL_DAY,
		SEL_HOUR,
		SEL_MIN
	} sel_t;

	typedef struct packed {
		op_t  op;
		sel_t sel;
		upc_t next;
	} uword_t;

	localparam upc_t UA_WAIT  = UPC_W'(0);
	localparam upc_t UA_YEAR  = UPC_W'(1);
	localparam upc_t UA_MONTH = UPC_W'(2);
	localparam upc_t UA_DAY   = UPC_W'(3);
	localparam upc_t UA_HOUR  = UPC_W'(4);
	localparam upc_t UA_MIN   = UPC_W'(5);
	localparam upc_t UA_EMIT  = UPC_W'(6);

	function automatic uword_t ucode(input upc_t a);
		uword_t w;
		begin
			case (a)
				UA_WAIT:  w = '{op: OP_WAIT, sel: SEL_YEAR,  next: UA_YEAR};
				UA_YEAR:  w = '{op: OP_LOOP, sel: SEL_YEAR,  next: UA_MONTH};
				UA_MONTH: w = '{op: OP_LOOP, sel: SEL_MONTH, next: UA_DAY};
				UA_DAY:   w = '{op: OP_LOOP, sel: SEL_DAY,   next: UA_HOUR};
				UA_HOUR:  w = '{op: OP_LOOP, sel: SEL_HOUR,  next: UA_MIN};
				UA_MIN:   w = '{op: OP_LOOP, sel: SEL_MIN,   next: UA_EMIT};
				UA_EMIT:  w = '{op: OP_EMIT, sel: SEL_YEAR,  next: UA_WAIT};
				default:  w = '{op: OP_WAIT, sel: SEL_YEAR,  next: UA_YEAR};
			endcase
			return w;
		end
	endfunction

	// Years reachable from a 32-bit count run 1970..2106; 2100 is the only
	// multiple of 100 in there and it is not a multiple of 400.
	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		return (y[1:0] == 2'b00) && (y != NOLEAP_CENTURY);
	endfunction

	function automatic logic [LEN_W-1:0] month_secs(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [LEN_W-1:0] d;
		begin
			case (m)
				4'd1:    d = leap ? LEN_W'(29) : LEN_W'(28);
				4'd3,
				4'd5,
				4'd8,
				4'd10:   d = LEN_W'(30);
				default: d = LEN_W'(31);
			endcase
			return LEN_W'(d * SECS_PER_DAY);
		end
	endfunction

endpackage

>>> design/epoch_seconds_to_calendar.sv
// Channel   Dir  Word                                   Handshake
// s_axis    in   tdata[31:0] = epoch_seconds           tvalid/tready
// m_axis    out  tdata[39:0] = year,month,day,hour,     tvalid/tready
//                 minute,second (low bit up), [39:38]=0
//
// One word at a time. A short microprogram steps a single 32-bit
// compare/subtract unit through five loops: whole years, months, days,
// hours, minutes, then hands the result on at its emit step and returns
// to its wait step for the next word. s_tready is high only while the
// sequencer sits in its wait step. The result sits in an output register;
// a stalled master side holds the sequencer at its emit step. arst_n
// clears the step counter and out valid.
module epoch_seconds_to_calendar (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [esc_pkg::IN_W-1:0]   s_tdata,   // [31:0] epoch_seconds
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [esc_pkg::OUT_W-1:0]  m_tdata    // year, month, day, hour,
	                                               // minute, second; zero pad
);
	import esc_pkg::*;

	upc_t                 upc_q;
	logic [REM_W-1:0]     rem_q;
	logic [YEAR_W-1:0]    year_q;
	logic [MONTH_W-1:0]   mon_q;     // zero-based
	logic [DAY_W-1:0]     day_q;     // zero-based
	logic [HOUR_W-1:0]    hour_q;
	logic [MIN_W-1:0]     min_q;
	logic                 out_valid_q;
	logic [OUT_W-1:0]     out_data_q;

	uword_t               uw;
	logic [LEN_W-1:0]     len;
	logic                 fits;
	logic                 guard;
	logic                 out_free;
	logic [FIELD_W-1:0]   fields;

	assign uw = ucode(upc_q);

	// step length for the loop in progress
	always_comb begin
		case (uw.sel)
			SEL_YEAR:  len = is_leap(year_q) ? SECS_LEAP_YEAR : SECS_YEAR;
			SEL_MONTH: len = month_secs(mon_q, is_leap(year_q));
			SEL_DAY:   len = SECS_PER_DAY;
			SEL_HOUR:  len = SECS_PER_HOUR;
			SEL_MIN:   len = SECS_PER_MIN;
			default:   len = SECS_PER_MIN;
		endcase
	end

	assign fits     = rem_q >= REM_W'(len);
	// December is the last month; never step past it
	assign guard    = (uw.sel == SEL_MONTH) && (mon_q >= MONTH_LAST);
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (uw.op == OP_WAIT);

	// remainder below a minute is the seconds field
	assign fields = {rem_q[SEC_W-1:0], min_q, hour_q, DAY_W'(day_q + 1'b1),
		MONTH_W'(mon_q + 1'b1), year_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= UA_WAIT;
			out_valid_q <= 1'b0;
		end else begin
			// a new result replaces the one leaving this cycle
			if ((uw.op == OP_EMIT) && out_free)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			case (uw.op)
				OP_WAIT: begin
					if (s_tvalid)
						upc_q <= uw.next;
				end
				OP_LOOP: begin
					if (!fits || guard)
						upc_q <= uw.next;
				end
				OP_EMIT: begin
					if (out_free)
						upc_q <= uw.next;
				end
				default: upc_q <= UA_WAIT;
			endcase
		end
	end

	// datapath: no reset needed
	always_ff @(posedge clk) begin
		case (uw.op)
			OP_WAIT: begin
				if (s_tvalid) begin
					rem_q  <= s_tdata;
					year_q <= BASE_YEAR;
					mon_q  <= '0;
					day_q  <= '0;
					hour_q <= '0;
					min_q  <= '0;
				end
			end
			OP_LOOP: begin
				if (fits && !guard) begin
					rem_q <= rem_q - REM_W'(len);
					case (uw.sel)
						SEL_YEAR:  year_q <= year_q + 1'b1;
						SEL_MONTH: mon_q  <= mon_q + 1'b1;
						SEL_DAY:   day_q  <= day_q + 1'b1;
						SEL_HOUR:  hour_q <= hour_q + 1'b1;
						SEL_MIN:   min_q  <= min_q + 1'b1;
						default:   min_q  <= min_q;
					endcase
				end
			end
			OP_EMIT: begin
				if (out_free)
					out_data_q <= OUT_W'(fields);
			end
			default: rem_q <= rem_q;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

>>> sim/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import esc_pkg::*;

	// Stall idle cycles before the run is declared hung. The limit must cover the
	// slowest word inside the block, plus the longest output hold and input gap.
	localparam int HANG_LIMIT   = 5000;
	localparam int DRAIN_CYCLES = 300;   // quiet time after the last result
	localparam int RANDOM_WORDS = 1150;

	// Output word layout, low bit up: year, month, day, hour, minute, second, pad
	localparam int MONTH_LO  = YEAR_W;
	localparam int DAY_LO    = MONTH_LO + MONTH_W;
	localparam int HOUR_LO   = DAY_LO + DAY_W;
	localparam int MIN_LO    = HOUR_LO + HOUR_W;
	localparam int SEC_LO    = MIN_LO + MIN_W;

	typedef struct {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [HOUR_W-1:0]  hour;
		logic [MIN_W-1:0]   minute;
		logic [SEC_W-1:0]   second;
	} calendar_t;

	// Output-side receiver behavior; a new one is picked at random after each stretch
	typedef enum logic [1:0] {
		RX_OPEN,    // always ready
		RX_COIN,    // ready about half the time
		RX_SPARSE,  // ready about a quarter of the time
		RX_HOLD     // stalled for the whole stretch
	} rx_mode_t;

	// Dates pending on the output side, oldest first, and the checker
	class calendar_scoreboard;
		localparam int unsigned MIN_SECS  = 60;
		localparam int unsigned HOUR_SECS = 60 * 60;
		localparam int unsigned DAY_SECS  = 24 * 60 * 60;
		localparam int unsigned EPOCH_YEAR = 1970;

		calendar_t dates_due[$];
		int        errors;

		function new();
			errors = 0;
		endfunction

		// Full Gregorian rule, not just the 1970..2106 shortcut
		static function bit is_leap_year(int unsigned y);
			return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		endfunction

		static function int unsigned days_in_month(int unsigned m, bit leap);
			case (m)
				2:           return leap ? 29 : 28;
				4, 6, 9, 11: return 30;
				default:     return 31;
			endcase
		endfunction

		// Walk whole years, then whole months, then split what is left
		function calendar_t to_calendar(logic [31:0] secs);
			calendar_t   c;
			int unsigned left;
			int unsigned y;
			int unsigned m;
			int unsigned span;
			left = secs;
			y = EPOCH_YEAR;
			while (1) begin
				span = (is_leap_year(y) ? 366 : 365) * DAY_SECS;
				if (left < span)
					break;
				left -= span;
				y++;
			end
			m = 1;
			// December is never passed; the bound just keeps the walk finite
			while (m < 12) begin
				span = days_in_month(m, is_leap_year(y)) * DAY_SECS;
				if (left < span)
					break;
				left -= span;
				m++;
			end
			c.year   = YEAR_W'(y);
			c.month  = MONTH_W'(m);
			c.day    = DAY_W'(left / DAY_SECS + 1);
			left     = left % DAY_SECS;
			c.hour   = HOUR_W'(left / HOUR_SECS);
			left     = left % HOUR_SECS;
			c.minute = MIN_W'(left / MIN_SECS);
			c.second = SEC_W'(left % MIN_SECS);
			return c;
		endfunction

		function void note_seconds(logic [IN_W-1:0] secs);
			dates_due.push_back(to_calendar(secs));
		endfunction

		function int pending();
			return dates_due.size();
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_word(logic [OUT_W-1:0] w);
			calendar_t want;
			if (dates_due.size() == 0) begin
				$display("%0t: output word %h with no date pending", $time, w);
				errors++;
				return;
			end
			want = dates_due.pop_front();
			compare_field("year",   want.year,   w[MONTH_LO-1:0]);
			compare_field("month",  want.month,  w[DAY_LO-1:MONTH_LO]);
			compare_field("day",    want.day,    w[HOUR_LO-1:DAY_LO]);
			compare_field("hour",   want.hour,   w[MIN_LO-1:HOUR_LO]);
			compare_field("minute", want.minute, w[SEC_LO-1:MIN_LO]);
			compare_field("second", want.second, w[FIELD_W-1:SEC_LO]);
			compare_field("pad",    0,           w[OUT_W-1:FIELD_W]);
		endfunction
	endclass

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata  = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;

	calendar_scoreboard dates = new();

	int       burst_left  = 0;
	int       idle_cycles = 0;
	rx_mode_t rx_mode     = RX_OPEN;
	int       rx_left     = 0;

	epoch_seconds_to_calendar dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),    // [31:0] epoch_seconds
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)     // year, month, day, hour, minute, second, pad
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Inputs and outputs are sampled at the edge, before the block's own
	// updates land, so both monitors see the values of the closing cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				dates.note_seconds(s_tdata);
			if (m_tvalid && m_tready)
				dates.check_word(m_tdata);
		end
	end

	// Hang detector: any accepted word on either side restarts the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, HANG_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Receiver: stretches of open flow, coin flips, sparse accepts and solid
	// stalls, so the emit step sees back-pressure at random points.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
				rx_left <= $urandom_range(8, 64);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_mode)
				RX_OPEN:   m_tready <= 1'b1;
				RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
				RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
				default:   m_tready <= 1'b0;
			endcase
		end
	end

	// Seconds count of a calendar date; 64-bit so dates past 2106-02-07 show up
	function automatic longint unsigned date_to_seconds(int unsigned y, int unsigned mo,
			int unsigned d, int unsigned h, int unsigned mi, int unsigned s);
		longint unsigned days;
		days = 0;
		for (int unsigned yy = 1970; yy < y; yy++)
			days += calendar_scoreboard::is_leap_year(yy) ? 366 : 365;
		for (int unsigned mm = 1; mm < mo; mm++)
			days += calendar_scoreboard::days_in_month(mm, calendar_scoreboard::is_leap_year(y));
		days += d - 1;
		return days * 86400 + h * 3600 + mi * 60 + s;
	endfunction

	// Biased toward the ends of a range
	function automatic int unsigned edge_pick(int unsigned lo, int unsigned hi);
		case ($urandom_range(0, 3))
			0:       return lo;
			1:       return hi;
			default: return $urandom_range(lo, hi);
		endcase
	endfunction

	// Random date with its fields pushed toward month, day and year rollovers,
	// sometimes nudged by one second across the boundary
	function automatic logic [IN_W-1:0] boundary_seconds();
		int unsigned     y;
		int unsigned     mo;
		int unsigned     d;
		longint unsigned secs;
		y  = edge_pick(1970, 2106);
		mo = edge_pick(1, 12);
		d  = edge_pick(1, calendar_scoreboard::days_in_month(mo,
				calendar_scoreboard::is_leap_year(y)));
		secs = date_to_seconds(y, mo, d, edge_pick(0, 23), edge_pick(0, 59), edge_pick(0, 59));
		case ($urandom_range(0, 3))
			0:       secs = secs + 1;
			1:       secs = secs - 1;
			default: ;
		endcase
		// past the 32-bit range or below the epoch: plain random instead
		if (secs > 64'hFFFF_FFFF)
			return $urandom;
		return secs[31:0];
	endfunction

	// Sender: bursts of back-to-back words with random gaps between them.
	// Mostly short gaps, now and then one long enough to span a whole conversion.
	task automatic send_seconds(logic [IN_W-1:0] secs);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 280) : $urandom_range(0, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				s_tdata  <= $urandom;   // junk while idle
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= secs;
		do @(posedge clk); while (!s_tready);
	endtask

	initial begin
		logic [IN_W-1:0] corner [$];
		corner = '{
			32'd0,              // the epoch itself
			32'd1,
			32'd59,             // minute rollover
			32'd60,
			32'd3599,           // hour rollover
			32'd86399,          // last second of day one
			32'd86400,
			32'd31535999,       // end of 1970
			32'd31536000,       // first second of 1971
			32'd68169600,       // first leap day, 1972-02-29
			32'd94694399,       // last second of a leap year
			32'd951782400,      // 2000-02-29, century that is leap
			32'd978307199,      // end of 2000
			32'h7FFF_FFFF,      // signed 32-bit rollover
			32'h8000_0000,
			32'd4107542399,     // 2100-02-28 23:59:59, century that is not leap
			32'd4107542400,     // 2100-03-01 follows directly
			32'hAAAA_AAAA,
			32'h5555_5555,
			32'hFFFF_FFFE,
			32'hFFFF_FFFF       // latest date, 2106-02-07 06:28:15
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (corner[i])
			send_seconds(corner[i]);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: send_seconds($urandom);
				9:          send_seconds($urandom_range(0, 200000000));
				default:    send_seconds(boundary_seconds());
			endcase
		end
		s_tvalid <= 1'b0;

		while (dates.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (dates.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
